// ----- sv/gray_world_white_balance_unit_macros.svh -----
// Assertion macros shared by the checker.
`ifndef GRAY_WORLD_WHITE_BALANCE_UNIT_MACROS_SVH
`define GRAY_WORLD_WHITE_BALANCE_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define GW_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define GW_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ----- sv/gwwb_pkg.sv -----
// ----------------------------------------------------------------------------
// gwwb_pkg
// Types and constants of the gray-world white balance unit.
// ----------------------------------------------------------------------------
package gwwb_pkg;
    localparam int unsigned MaxPixels = 65536;
    localparam int unsigned CntW = $clog2(MaxPixels + 1);
    localparam int unsigned AddrW = $clog2(MaxPixels);

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StNotDone = 2'd1;
    localparam logic [1:0] StIndex   = 2'd2;
    localparam logic [1:0] StFull    = 2'd3;

    localparam logic CmdLoad = 1'b0;
    localparam logic CmdRead = 1'b1;

    // Divider operand width: sums reach 24 bits.
    localparam int unsigned DivW = 24;

    typedef struct packed {
        logic        command;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic        last_pixel;
        logic [15:0] pixel_index;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
    } t_out;

    typedef struct packed {
        logic            start;
        logic [DivW-1:0] num;
        logic [DivW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [DivW-1:0] quo;
        logic [DivW-1:0] rem;
    } t_div_rsp;
endpackage

// ----- sv/gwwb_divider.sv -----
// ----------------------------------------------------------------------------
// gwwb_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gwwb_divider
    import gwwb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int unsigned StepW = $clog2(DivW + 1);

    logic [DivW-1:0]  r_quo, n_quo;
    logic [DivW-1:0]  r_rem, n_rem;
    logic [DivW-1:0]  r_den;
    logic [StepW-1:0] r_step;
    logic             r_busy, r_done;
    logic [DivW:0]    w_trial;

    always_comb begin
        w_trial = {r_rem, r_quo[DivW-1]} - {1'b0, r_den};
        n_quo = {r_quo[DivW-2:0], ~w_trial[DivW]};
        n_rem = w_trial[DivW] ? {r_rem[DivW-2:0], r_quo[DivW-1]} : w_trial[DivW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_quo  <= i_req.num;
                r_rem  <= '0;
                r_den  <= i_req.den;
                r_step <= StepW'(DivW);
            end else if (r_busy) begin
                r_quo  <= n_quo;
                r_rem  <= n_rem;
                r_step <= r_step - 1'b1;
                if (r_step == StepW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp = '{done: r_done, quo: r_quo, rem: r_rem};
endmodule

// ----- sv/gray_world_white_balance_unit.sv -----
// ----------------------------------------------------------------------------
// gray_world_white_balance_unit
// Gray-world white balance with min-max normalization over a frame store.
// ----------------------------------------------------------------------------
// A command transaction is taken when start is high and busy is low.
// A load command stores one BGR pixel and updates per-channel sums, minima
// and maxima; a load marked last completes the frame. A read command returns
// the stored pixel scaled by target_mean/average and normalized to 0..255.
// Every command gives exactly one result, shown for one cycle with o_done;
// the receiver cannot stall it.
// All divisions pass through one shared 24-step divider. A load on the last
// pixel runs three averages and six extreme scalings. A read that fails
// answers without a divide; otherwise it runs three scalings and up to three
// normalizing divides. A target_mean write with a complete frame recomputes
// the extremes (six scalings) with busy high.
// The configuration channel is i_cfg_valid/o_cfg_ready, ready only while idle
// with start low. Reset clears statistics; the frame store holds undefined
// data until loaded, and reads are bounded by the pixel count.
// ----------------------------------------------------------------------------
module gray_world_white_balance_unit
    import gwwb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_in        i_cmd,
    output logic       o_done,
    output t_out       o_res,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_LOAD  = 11'b00000000010,
        S_AVG   = 11'b00000000100,
        S_AVGW  = 11'b00000001000,
        S_EXT   = 11'b00000010000,
        S_EXTW  = 11'b00000100000,
        S_RDMEM = 11'b00001000000,
        S_SCL   = 11'b00010000000,
        S_SCLW  = 11'b00100000000,
        S_NRM   = 11'b01000000000,
        S_NRMW  = 11'b10000000000
    } t_state;

    t_state r_state;

    logic [23:0]     frame_mem [MaxPixels];
    logic [23:0]     r_word;
    logic [CntW-1:0] r_count;
    logic [23:0]     r_sum [3];
    logic [7:0]      r_min [3];
    logic [7:0]      r_max [3];
    logic [7:0]      r_avg [3];
    logic [7:0]      r_lo, r_hi;
    logic            r_ready;
    logic [7:0]      r_target;
    logic [1:0]      r_ch;
    logic            r_sel;      // extremes: 0 min, 1 max
    logic [7:0]      r_scl [3];
    logic [7:0]      r_olo, r_ohi;
    logic [15:0]     r_idx;
    logic            r_done;
    t_out            r_res;
    t_div_req        w_req;
    t_div_rsp        w_rsp;

    gwwb_divider u_div (.i_clk, .i_rst_n, .i_req(w_req), .o_rsp(w_rsp));

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign o_done      = r_done;
    assign o_res       = r_res;

    logic [7:0] w_p, w_a, w_v;
    logic [15:0] w_prod;
    logic [7:0]  w_sat;
    logic [7:0]  w_nq;
    logic [8:0]  w_den;

    // Divider operand selection: averages, scaling of the channel or extreme in turn, and normalizing.
    always_comb begin
        if (r_state == S_EXT || r_state == S_EXTW) begin
            w_p = r_sel ? r_max[r_ch] : r_min[r_ch];
        end else begin
            w_p = r_word[8*r_ch +: 8];
        end
        w_a    = r_avg[r_ch];
        w_prod = r_target * w_p;
        w_sat  = (w_rsp.quo > 24'd255) ? 8'd255 : w_rsp.quo[7:0];
        w_v    = r_scl[r_ch];
        if (w_v < r_lo) w_v = r_lo;
        if (w_v > r_hi) w_v = r_hi;
        w_den  = {1'b0, r_hi} - {1'b0, r_lo};
        w_nq   = w_rsp.quo[7:0];
        if (({w_rsp.rem[8:0], 1'b0} > {1'b0, w_den})
            || (({w_rsp.rem[8:0], 1'b0} == {1'b0, w_den}) && w_rsp.quo[0]))
            w_nq = w_rsp.quo[7:0] + 8'd1;
        w_req = '{start: 1'b0, num: '0, den: '0};
        unique case (r_state)
            S_AVG: w_req = '{start: 1'b1, num: r_sum[r_ch],
                             den: DivW'(r_count)};
            S_EXT, S_SCL: w_req = '{start: (w_a != 8'd0), num: DivW'(w_prod),
                                   den: DivW'(w_a)};
            S_NRM: w_req = '{start: 1'b1,
                             num: DivW'(16'(w_v - r_lo) * 16'd255),
                             den: DivW'(w_den)};
            default: ;
        endcase
    end

    // Scaled value once the divide or the zero-average rule is settled.
    logic [7:0] w_scaled;
    logic       w_sc_ok;
    always_comb begin
        w_sc_ok  = (w_a == 8'd0) || w_rsp.done;
        w_scaled = (w_a == 8'd0) ? ((w_p != 8'd0) ? 8'd255 : 8'd0) : w_sat;
    end

    // A load after a completed frame starts the new frame at address zero.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start && i_cmd.command == CmdLoad
            && (r_ready || r_count < CntW'(MaxPixels)))
            frame_mem[r_ready ? AddrW'(0) : r_count[AddrW-1:0]]
                <= {i_cmd.red, i_cmd.green, i_cmd.blue};
        r_word <= frame_mem[r_idx[AddrW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ready  <= 1'b0;
            r_target <= 8'd128;
            r_lo     <= '0;
            r_hi     <= '0;
            r_done   <= 1'b0;
            r_ch     <= '0;
            r_sel    <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= '0;
                r_min[c] <= 8'd255;
                r_max[c] <= '0;
                r_avg[c] <= '0;
            end
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_res <= '{status: StOk, out_blue: 8'd0, out_green: 8'd0,
                                   out_red: 8'd0};
                        r_idx <= i_cmd.pixel_index;
                        if (i_cmd.command == CmdLoad) begin
                            logic [7:0] px [3];
                            logic [CntW-1:0] cnt;
                            px[0] = i_cmd.blue;
                            px[1] = i_cmd.green;
                            px[2] = i_cmd.red;
                            cnt = r_ready ? '0 : r_count;
                            r_ready <= 1'b0;
                            if (cnt >= CntW'(MaxPixels)) begin
                                r_res.status <= StFull;
                                if (r_ready) begin
                                    r_count <= '0;
                                end
                            end else begin
                                r_count <= cnt + 1'b1;
                            end
                            for (int c = 0; c < 3; c++) begin
                                logic [23:0] s;
                                logic [7:0]  mn, mx;
                                s  = r_ready ? 24'd0 : r_sum[c];
                                mn = r_ready ? 8'd255 : r_min[c];
                                mx = r_ready ? 8'd0 : r_max[c];
                                if (cnt < CntW'(MaxPixels)) begin
                                    s = s + 24'(px[c]);
                                    if (px[c] < mn) mn = px[c];
                                    if (px[c] > mx) mx = px[c];
                                end
                                r_sum[c] <= s;
                                r_min[c] <= mn;
                                r_max[c] <= mx;
                            end
                            r_ch  <= '0;
                            r_sel <= 1'b0;
                            r_state <= (i_cmd.last_pixel
                                        && (cnt < CntW'(MaxPixels) || cnt != '0))
                                       ? S_AVG : S_LOAD;
                        end else if (!r_ready) begin
                            r_res.status <= StNotDone;
                            r_done <= 1'b1;
                        end else if ({1'b0, i_cmd.pixel_index} >= CntW'(r_count)) begin
                            r_res.status <= StIndex;
                            r_done <= 1'b1;
                        end else begin
                            r_ch    <= '0;
                            r_state <= S_RDMEM;
                        end
                    end else if (i_cfg_valid && o_cfg_ready) begin
                        r_target <= i_cfg_data;
                        if (r_ready) begin
                            r_ch    <= '0;
                            r_sel   <= 1'b0;
                            r_olo   <= 8'd255;
                            r_ohi   <= 8'd0;
                            r_state <= S_EXT;
                        end
                    end
                end
                S_LOAD: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_AVG: r_state <= S_AVGW;
                S_AVGW: begin
                    if (w_rsp.done) begin
                        r_avg[r_ch] <= w_rsp.quo[7:0];
                        if (r_ch == 2'd2) begin
                            r_ch    <= '0;
                            r_olo   <= 8'd255;
                            r_ohi   <= 8'd0;
                            r_state <= S_EXT;
                        end else begin
                            r_ch    <= r_ch + 2'd1;
                            r_state <= S_AVG;
                        end
                    end
                end
                S_EXT: r_state <= (w_a == 8'd0) ? S_EXTW : S_EXTW;
                S_EXTW: begin
                    if (w_sc_ok) begin
                        logic [7:0] lo, hi;
                        lo = r_olo;
                        hi = r_ohi;
                        if (!r_sel && w_scaled < lo) lo = w_scaled;
                        if (r_sel && w_scaled > hi) hi = w_scaled;
                        r_olo <= lo;
                        r_ohi <= hi;
                        if (r_sel && r_ch == 2'd2) begin
                            r_lo    <= lo;
                            r_hi    <= hi;
                            r_ready <= 1'b1;
                            // A load that completes the frame still owes its
                            // result; a target_mean rewrite owes none.
                            r_state <= r_ready ? S_IDLE : S_LOAD;
                        end else begin
                            if (r_sel) r_ch <= r_ch + 2'd1;
                            r_sel   <= ~r_sel;
                            r_state <= S_EXT;
                        end
                    end
                end
                S_RDMEM: r_state <= S_SCL;
                S_SCL: r_state <= S_SCLW;
                S_SCLW: begin
                    if (w_sc_ok) begin
                        r_scl[r_ch] <= w_scaled;
                        if (r_ch == 2'd2) begin
                            r_ch    <= '0;
                            r_state <= S_NRM;
                        end else begin
                            r_ch    <= r_ch + 2'd1;
                            r_state <= S_SCL;
                        end
                    end
                end
                S_NRM: begin
                    if (r_hi <= r_lo) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_NRMW;
                    end
                end
                S_NRMW: begin
                    if (w_rsp.done) begin
                        unique case (r_ch)
                            2'd0: r_res.out_blue  <= w_nq;
                            2'd1: r_res.out_green <= w_nq;
                            default: r_res.out_red <= w_nq;
                        endcase
                        if (r_ch == 2'd2) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_ch    <= r_ch + 2'd1;
                            r_state <= S_NRM;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- sv/gwwb_checker.sv -----
// ----------------------------------------------------------------------------
// gwwb_checker
// Port-level checks of the white balance unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "gray_world_white_balance_unit_macros.svh"
module gwwb_checker
    import gwwb_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input t_out o_res,
    input logic o_cfg_ready
);
    // A taken command makes the block busy or answers in the next cycle.
    `GW_ASSERT_NXT(a_take, i_clk, i_rst_n, start && !busy, busy || o_done)
    // The configuration channel is never ready while the block is busy.
    `GW_ASSERT_IMP(a_cfg, i_clk, i_rst_n, busy, !o_cfg_ready)
    // Results with a nonzero status carry zero pixels.
    `GW_ASSERT_IMP(a_zero, i_clk, i_rst_n, o_done && o_res.status != StOk,
                   o_res.out_blue == 8'd0 && o_res.out_green == 8'd0
                   && o_res.out_red == 8'd0)
    // A result is only shown once the block is idle again.
    `GW_ASSERT_IMP(a_idle, i_clk, i_rst_n, o_done, !busy)
endmodule

bind gray_world_white_balance_unit gwwb_checker u_chk (
    .i_clk, .i_rst_n, .start, .busy, .o_done, .o_res, .o_cfg_ready
);
